@@ hdl/owtr_pkg.sv @@
package owtr_pkg;

  // Field and register widths
  localparam int unsigned CNT_W     = 16;
  localparam int unsigned SLOT_W    = 8;
  localparam int unsigned PHASE_W   = 5;
  localparam int unsigned BIT_W     = 3;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned TEMP_W    = 12;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_UNIT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_LOW_TICKS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONVERT_WAIT_UNITS = 2'd2;

  // Register reset values
  localparam logic [CNT_W-1:0]  RST_TICKS_PER_UNIT     = 16'd100;
  localparam logic [SLOT_W-1:0] RST_SLOT_LOW_TICKS     = 8'd2;
  localparam logic [CNT_W-1:0]  RST_CONVERT_WAIT_UNITS = 16'd200;

  // Sequence step numbers
  localparam logic [PHASE_W-1:0] PH_IDLE  = 5'd0;
  localparam logic [PHASE_W-1:0] PH_FIRST = 5'd1;
  localparam logic [PHASE_W-1:0] PH_LAST  = 5'd25;

  // Segment lengths in delay units
  localparam logic [CNT_W-1:0] UNITS_PRE  = 16'd12;
  localparam logic [CNT_W-1:0] UNITS_LOW  = 16'd80;
  localparam logic [CNT_W-1:0] UNITS_WAIT = 16'd10;
  localparam logic [CNT_W-1:0] UNITS_GAP  = 16'd5;

  // Bus commands
  localparam logic [BYTE_W-1:0] CMD_SKIP_ROM = 8'hCC;
  localparam logic [BYTE_W-1:0] CMD_CONVERT  = 8'h44;
  localparam logic [BYTE_W-1:0] CMD_READ_SP  = 8'hBE;
  localparam logic [BYTE_W-1:0] CMD_NONE     = 8'h00;

  localparam logic [BIT_W-1:0] BIT_LAST = 3'd7;

  typedef enum logic [3:0] {
    K_IDLE, K_PRE, K_LOW, K_WAIT, K_POST, K_WSLOT, K_WDATA,
    K_WGAP, K_CONV, K_RSLOT, K_RREC
  } kind_t;

  // Timing registers with zero already read as one
  typedef struct packed {
    logic [CNT_W-1:0]  ticks_per_unit;
    logic [SLOT_W-1:0] slot_low_ticks;
    logic [CNT_W-1:0]  convert_wait_units;
  } cfg_t;

  // Sequencer to segment timer
  typedef struct packed {
    logic             step;
    logic             ticks_mode;
    logic [CNT_W-1:0] units;
  } tmr_ctrl_t;

  // Segment timer to sequencer
  typedef struct packed {
    logic last;
    logic first;
  } tmr_stat_t;

  function automatic kind_t kind_of(input logic [PHASE_W-1:0] ph);
    kind_t k;
    case (ph) inside
      5'd1, 5'd12:               k = K_PRE;
      5'd2, 5'd13:               k = K_LOW;
      5'd3, 5'd14:               k = K_WAIT;
      5'd4, 5'd15:               k = K_POST;
      5'd5, 5'd8, 5'd16, 5'd19:  k = K_WSLOT;
      5'd6, 5'd9, 5'd17, 5'd20:  k = K_WDATA;
      5'd7, 5'd10, 5'd18, 5'd21: k = K_WGAP;
      5'd11:                     k = K_CONV;
      5'd22, 5'd24:              k = K_RSLOT;
      5'd23, 5'd25:              k = K_RREC;
      default:                   k = K_IDLE;
    endcase
    return k;
  endfunction

  function automatic logic [BYTE_W-1:0] cmd_of(input logic [PHASE_W-1:0] ph);
    logic [BYTE_W-1:0] c;
    case (ph) inside
      5'd5, 5'd6, 5'd7, 5'd16, 5'd17, 5'd18: c = CMD_SKIP_ROM;
      5'd8, 5'd9, 5'd10:                     c = CMD_CONVERT;
      5'd19, 5'd20, 5'd21:                   c = CMD_READ_SP;
      default:                               c = CMD_NONE;
    endcase
    return c;
  endfunction

endpackage

@@ hdl/owtr_if.sv @@
interface owtr_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic line_level;

  modport source(output valid, start_req, line_level, input ready);
  modport sink(input valid, start_req, line_level, output ready);
endinterface

interface owtr_out_if;
  logic        valid;
  logic        ready;
  logic        drive_low;
  logic        busy_res;
  logic        done_res;
  logic        presence_seen;
  logic [11:0] temperature;

  modport source(output valid, drive_low, busy_res, done_res, presence_seen, temperature,
                 input ready);
  modport sink(input valid, drive_low, busy_res, done_res, presence_seen, temperature,
               output ready);
endinterface

interface owtr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ hdl/onewire_temperature_reader_top.sv @@
// Channel  Dir  Words                                        Accept
// in_ch    in   start_req, line_level                        valid && ready
// out_ch   out  drive_low, busy_res, done_res,               valid && ready
//               presence_seen, temperature[11:0]
// cfg_ch   in   index[1:0], data[15:0] (0 ticks/unit,        valid && ready (always ready)
//               1 slot low ticks, 2 convert wait units)
//
// Cycles: one input word is one bus tick; its result word is valid on the next clock.
//   One word per clock sustained while out_ch does not stall.
// The output register is the only buffer: in_ch.ready = !out valid || out ready.
// Reset (rst_n low, synchronous) returns to idle, clears the reading and the
//   presence flag and loads the timing registers with 100 / 2 / 200.
// A stall on out_ch stops the sequencer; bus time counts in accepted words only.
module onewire_temperature_reader_top (
  input  logic       clk,
  input  logic       rst_n,
  owtr_in_if.sink    in_ch,
  owtr_out_if.source out_ch,
  owtr_cfg_if.sink   cfg_ch
);
  import owtr_pkg::*;

  cfg_t      cfg;
  tmr_ctrl_t tmr_ctrl;
  tmr_stat_t tmr_stat;

  // registers are always writable; the user must write them only with no word in flight (not enforced here)
  assign cfg_ch.ready = 1'b1;

  owtr_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  // tick and delay-unit counters for the current bus segment
  owtr_timer u_timer (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .ctrl  (tmr_ctrl),
    .stat  (tmr_stat)
  );

  // step sequencer, bit shifter and output register
  owtr_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .start_req     (in_ch.start_req),
    .line_level    (in_ch.line_level),
    .tmr_ctrl      (tmr_ctrl),
    .tmr_stat      (tmr_stat),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .drive_low     (out_ch.drive_low),
    .busy_res      (out_ch.busy_res),
    .done_res      (out_ch.done_res),
    .presence_seen (out_ch.presence_seen),
    .temperature   (out_ch.temperature)
  );

endmodule

@@ hdl/owtr_cfg_regs.sv @@
module owtr_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                wr_en,
  input  logic [owtr_pkg::CFG_IDX_W-1:0]      wr_index,
  input  logic [owtr_pkg::CFG_DAT_W-1:0]      wr_data,
  output owtr_pkg::cfg_t                      cfg
);
  import owtr_pkg::*;

  logic [CNT_W-1:0]  tpu_r;
  logic [SLOT_W-1:0] slot_r;
  logic [CNT_W-1:0]  conv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpu_r  <= RST_TICKS_PER_UNIT;
      slot_r <= RST_SLOT_LOW_TICKS;
      conv_r <= RST_CONVERT_WAIT_UNITS;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_TICKS_PER_UNIT:     tpu_r  <= wr_data[CNT_W-1:0];
        REG_SLOT_LOW_TICKS:     slot_r <= wr_data[SLOT_W-1:0];
        REG_CONVERT_WAIT_UNITS: conv_r <= wr_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // zero acts as one
  always_comb begin
    cfg.ticks_per_unit     = (tpu_r  == '0) ? CNT_W'(1)  : tpu_r;
    cfg.slot_low_ticks     = (slot_r == '0) ? SLOT_W'(1) : slot_r;
    cfg.convert_wait_units = (conv_r == '0) ? CNT_W'(1)  : conv_r;
  end

endmodule

@@ hdl/owtr_timer.sv @@
module owtr_timer (
  input  logic                clk,
  input  logic                rst_n,
  input  owtr_pkg::cfg_t      cfg,
  input  owtr_pkg::tmr_ctrl_t ctrl,
  output owtr_pkg::tmr_stat_t stat
);
  import owtr_pkg::*;

  logic [CNT_W-1:0] tick_r, tick_nxt;
  logic [CNT_W-1:0] unit_r, unit_nxt;
  logic [CNT_W:0]   tick_inc, unit_inc, tick_lim;
  logic             tick_more, unit_more;

  always_comb begin
    tick_inc  = {1'b0, tick_r} + 1'b1;
    unit_inc  = {1'b0, unit_r} + 1'b1;
    tick_lim  = ctrl.ticks_mode ? {{(CNT_W-SLOT_W+1){1'b0}}, cfg.slot_low_ticks}
                                : {1'b0, cfg.ticks_per_unit};
    tick_more = tick_inc < tick_lim;
    // units already at least one
    unit_more = unit_inc < {1'b0, ctrl.units};

    stat.first = (tick_r == '0) && (unit_r == '0);
    stat.last  = !tick_more && (ctrl.ticks_mode || !unit_more);

    tick_nxt = tick_r;
    unit_nxt = unit_r;
    if (ctrl.step) begin
      if (tick_more) begin
        tick_nxt = tick_inc[CNT_W-1:0];
      end else begin
        tick_nxt = '0;
        if (!ctrl.ticks_mode && unit_more) unit_nxt = unit_inc[CNT_W-1:0];
        else unit_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= '0;
      unit_r <= '0;
    end else begin
      tick_r <= tick_nxt;
      unit_r <= unit_nxt;
    end
  end

  // counters restart together at the end of a segment
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.step && stat.last) |=> (tick_r == '0 && unit_r == '0))
    else $error("segment end left a count running");

  a_ticks_no_units: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.step && ctrl.ticks_mode && unit_r == '0) |=> (unit_r == '0))
    else $error("unit count moved in a tick segment");

  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !ctrl.step |=> ($stable(tick_r) && $stable(unit_r)))
    else $error("timer moved without a step");

endmodule

@@ hdl/owtr_seq.sv @@
module owtr_seq (
  input  logic                                clk,
  input  logic                                rst_n,
  input  owtr_pkg::cfg_t                      cfg,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                start_req,
  input  logic                                line_level,
  output owtr_pkg::tmr_ctrl_t                 tmr_ctrl,
  input  owtr_pkg::tmr_stat_t                 tmr_stat,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                drive_low,
  output logic                                busy_res,
  output logic                                done_res,
  output logic                                presence_seen,
  output logic [owtr_pkg::TEMP_W-1:0]         temperature
);
  import owtr_pkg::*;

  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [BIT_W-1:0]   bit_r, bit_nxt;
  logic [BYTE_W-1:0]  shift_r, shift_nxt;
  logic [BYTE_W-1:0]  low_r, low_nxt;
  logic [TEMP_W-1:0]  temp_r, temp_nxt;
  logic               pres_r, pres_nxt;

  logic               ovalid_r;
  logic               drive_r, busy_r, done_r;

  logic [PHASE_W-1:0] ph, enter_ph;
  kind_t              kind, enter_kind;
  logic               accept, do_enter, drive, done;
  logic [BYTE_W-1:0]  sampled;

  assign in_ready = !ovalid_r || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    ph       = (phase_r > PH_LAST) ? PH_IDLE : phase_r;
    kind     = kind_of(ph);

    tmr_ctrl.step       = accept && (kind != K_IDLE);
    tmr_ctrl.ticks_mode = (kind == K_WSLOT) || (kind == K_RSLOT);
    case (kind)
      K_PRE:   tmr_ctrl.units = UNITS_PRE;
      K_LOW:   tmr_ctrl.units = UNITS_LOW;
      K_WAIT:  tmr_ctrl.units = UNITS_WAIT;
      K_CONV:  tmr_ctrl.units = cfg.convert_wait_units;
      default: tmr_ctrl.units = UNITS_GAP;
    endcase

    phase_nxt = ph;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    low_nxt   = low_r;
    temp_nxt  = temp_r;
    pres_nxt  = pres_r;
    drive     = 1'b0;
    done      = 1'b0;
    do_enter  = 1'b0;
    enter_ph  = ph + 1'b1;
    sampled   = tmr_stat.first ? {line_level, shift_r[BYTE_W-1:1]} : shift_r;

    unique case (kind)
      K_IDLE: begin
        if (start_req) begin
          do_enter = 1'b1;
          enter_ph = PH_FIRST;
        end
      end
      K_PRE, K_POST, K_WGAP, K_CONV: begin
        do_enter = tmr_stat.last;
      end
      K_LOW: begin
        drive    = 1'b1;
        do_enter = tmr_stat.last;
      end
      K_WAIT: begin
        if (tmr_stat.last) begin
          pres_nxt = !line_level;
          do_enter = 1'b1;
        end
      end
      K_WSLOT, K_RSLOT: begin
        drive = 1'b1;
        if (tmr_stat.last) phase_nxt = ph + 1'b1;
      end
      K_WDATA: begin
        drive = !shift_r[0];
        if (tmr_stat.last) begin
          shift_nxt = shift_r >> 1;
          bit_nxt   = bit_r + 1'b1;
          if (bit_r == BIT_LAST) do_enter = 1'b1;
          else phase_nxt = ph - 1'b1;
        end
      end
      K_RREC: begin
        shift_nxt = sampled;
        if (tmr_stat.last) begin
          bit_nxt = bit_r + 1'b1;
          if (bit_r != BIT_LAST) begin
            phase_nxt = ph - 1'b1;
          end else if (ph == PH_LAST) begin
            temp_nxt = {sampled[3:0], low_r};
            done     = 1'b1;
            do_enter = 1'b1;
            enter_ph = PH_IDLE;
          end else begin
            low_nxt  = sampled;
            do_enter = 1'b1;
          end
        end
      end
      default: ;
    endcase

    // entering a slot step loads the byte to send or clears the one to read
    enter_kind = kind_of(enter_ph);
    if (do_enter) begin
      phase_nxt = enter_ph;
      if (enter_kind == K_WSLOT) begin
        shift_nxt = cmd_of(enter_ph);
        bit_nxt   = '0;
      end else if (enter_kind == K_RSLOT) begin
        shift_nxt = '0;
        bit_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      bit_r    <= '0;
      shift_r  <= '0;
      low_r    <= '0;
      temp_r   <= '0;
      pres_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r  <= phase_nxt;
        bit_r    <= bit_nxt;
        shift_r  <= shift_nxt;
        low_r    <= low_nxt;
        temp_r   <= temp_nxt;
        pres_r   <= pres_nxt;
        ovalid_r <= 1'b1;
      end else if (out_ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      drive_r <= drive;
      busy_r  <= (kind != K_IDLE);
      done_r  <= done;
    end
  end

  assign out_valid     = ovalid_r;
  assign drive_low     = drive_r;
  assign busy_res      = busy_r;
  assign done_res      = done_r;
  assign presence_seen = pres_r;
  assign temperature   = temp_r;

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= PH_LAST)
    else $error("step number out of range");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && phase_r == PH_IDLE && start_req) |=> (phase_r == PH_FIRST))
    else $error("start did not open the bus reset");

  a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && done) |=> (phase_r == PH_IDLE && done_res && busy_res))
    else $error("finished reading without returning to idle");

  a_idle_release: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && !busy_r) |-> !drive_r)
    else $error("line pulled low while idle");

endmodule

@@ verif/owtr_reading_check.sv @@
`timescale 1ns / 100ps

module owtr_reading_check (
  input  logic        clk,
  input  logic        rst_n,
  owtr_in_if          in_ch,
  owtr_out_if         out_ch,
  owtr_cfg_if         cfg_ch,
  output int unsigned fail_cnt,
  output int unsigned open_words,
  output int unsigned done_seen,
  output int unsigned words_checked
);
  import owtr_pkg::*;

  // Sequence step numbers and bus constants
  localparam logic [PHASE_W-1:0] SEQ_IDLE  = 5'd0;
  localparam logic [PHASE_W-1:0] SEQ_FIRST = 5'd1;
  localparam logic [PHASE_W-1:0] SEQ_LAST  = 5'd25;

  localparam logic [CNT_W-1:0] RESET_GAP_UNITS = 16'd12;
  localparam logic [CNT_W-1:0] RESET_LOW_UNITS = 16'd80;
  localparam logic [CNT_W-1:0] PRESENCE_UNITS  = 16'd10;
  localparam logic [CNT_W-1:0] SLOT_UNITS      = 16'd5;

  localparam logic [BYTE_W-1:0] OP_SKIP_ROM     = 8'hCC;
  localparam logic [BYTE_W-1:0] OP_CONVERT      = 8'h44;
  localparam logic [BYTE_W-1:0] OP_READ_SCRATCH = 8'hBE;

  localparam logic [CNT_W-1:0]  TPU_AT_RESET  = 16'd100;
  localparam logic [SLOT_W-1:0] SLOT_AT_RESET = 8'd2;
  localparam logic [CNT_W-1:0]  CWU_AT_RESET  = 16'd200;

  typedef struct packed {
    logic              drive;
    logic              busy;
    logic              done;
    logic              presence;
    logic [TEMP_W-1:0] temp;
  } reader_word_t;

  // timing registers
  logic [CNT_W-1:0]  r_tpu;
  logic [SLOT_W-1:0] r_slot;
  logic [CNT_W-1:0]  r_cwu;

  // sequencer state
  logic [PHASE_W-1:0] m_phase;
  logic [CNT_W-1:0]   m_ticks;
  logic [CNT_W-1:0]   m_units;
  logic [BIT_W-1:0]   m_bit;
  logic [BYTE_W-1:0]  m_shift;
  logic [BYTE_W-1:0]  m_low;
  logic [TEMP_W-1:0]  m_temp;
  logic               m_presence;

  reader_word_t expected_words[$];

  int unsigned n_fed     = 0;
  int unsigned n_matched = 0;
  int unsigned n_fail    = 0;
  int unsigned n_done    = 0;
  int unsigned n_words   = 0;

  assign fail_cnt      = n_fail;
  assign open_words    = n_fed - n_matched;
  assign done_seen     = n_done;
  assign words_checked = n_words;

  function automatic kind_t step_kind(input logic [PHASE_W-1:0] ph);
    case (ph)
      5'd1, 5'd12:               return K_PRE;
      5'd2, 5'd13:               return K_LOW;
      5'd3, 5'd14:               return K_WAIT;
      5'd4, 5'd15:               return K_POST;
      5'd5, 5'd8, 5'd16, 5'd19:  return K_WSLOT;
      5'd6, 5'd9, 5'd17, 5'd20:  return K_WDATA;
      5'd7, 5'd10, 5'd18, 5'd21: return K_WGAP;
      5'd11:                     return K_CONV;
      5'd22, 5'd24:              return K_RSLOT;
      5'd23, 5'd25:              return K_RREC;
      default:                   return K_IDLE;
    endcase
  endfunction

  function automatic logic [BYTE_W-1:0] step_opcode(input logic [PHASE_W-1:0] ph);
    if (ph >= 5'd5 && ph <= 5'd7)   return OP_SKIP_ROM;
    if (ph >= 5'd8 && ph <= 5'd10)  return OP_CONVERT;
    if (ph >= 5'd16 && ph <= 5'd18) return OP_SKIP_ROM;
    if (ph >= 5'd19 && ph <= 5'd21) return OP_READ_SCRATCH;
    return '0;
  endfunction

  // zero in a timing register counts as one
  function automatic logic [31:0] at_least_one(input logic [CNT_W-1:0] v);
    return (v == '0) ? 32'd1 : 32'(v);
  endfunction

  // true on the last tick of a segment of n delay units
  function automatic logic units_done(input logic [CNT_W-1:0] n);
    if (32'(m_ticks) + 32'd1 < at_least_one(r_tpu)) begin
      m_ticks = m_ticks + 1'b1;
      return 1'b0;
    end
    m_ticks = '0;
    if (32'(m_units) + 32'd1 < at_least_one(n)) begin
      m_units = m_units + 1'b1;
      return 1'b0;
    end
    m_units = '0;
    return 1'b1;
  endfunction

  function automatic logic slot_done();
    if (32'(m_ticks) + 32'd1 < at_least_one({8'd0, r_slot})) begin
      m_ticks = m_ticks + 1'b1;
      return 1'b0;
    end
    m_ticks = '0;
    m_units = '0;
    return 1'b1;
  endfunction

  function automatic void enter_step(input int unsigned nxt);
    m_phase = (nxt > 32'(SEQ_LAST)) ? SEQ_IDLE : PHASE_W'(nxt);
    m_ticks = '0;
    m_units = '0;
    if (step_kind(m_phase) == K_WSLOT) begin
      m_shift = step_opcode(m_phase);
      m_bit   = '0;
    end
    if (step_kind(m_phase) == K_RSLOT) begin
      m_shift = '0;
      m_bit   = '0;
    end
  endfunction

  // one bus tick of the master
  function automatic reader_word_t next_bus_word(input logic start, input logic level);
    logic [PHASE_W-1:0] p;
    kind_t              k;
    reader_word_t       w;
    p       = (m_phase > SEQ_LAST) ? SEQ_IDLE : m_phase;
    k       = step_kind(p);
    w       = '0;
    w.busy  = (k != K_IDLE);
    m_phase = p;
    case (k)
      K_IDLE: begin
        if (start) enter_step(32'(SEQ_FIRST));
      end
      K_PRE: begin
        if (units_done(RESET_GAP_UNITS)) enter_step(32'(p) + 1);
      end
      K_LOW: begin
        w.drive = 1'b1;
        if (units_done(RESET_LOW_UNITS)) enter_step(32'(p) + 1);
      end
      K_WAIT: begin
        if (units_done(PRESENCE_UNITS)) begin
          m_presence = ~level;
          enter_step(32'(p) + 1);
        end
      end
      K_POST, K_WGAP: begin
        if (units_done(SLOT_UNITS)) enter_step(32'(p) + 1);
      end
      K_CONV: begin
        if (units_done(r_cwu)) enter_step(32'(p) + 1);
      end
      K_WSLOT, K_RSLOT: begin
        w.drive = 1'b1;
        if (slot_done()) m_phase = p + 1'b1;
      end
      K_WDATA: begin
        w.drive = ~m_shift[0];
        if (units_done(SLOT_UNITS)) begin
          m_shift = m_shift >> 1;
          m_bit   = m_bit + 1'b1;
          if (m_bit == '0) enter_step(32'(p) + 1);
          else m_phase = p - 1'b1;
        end
      end
      default: begin
        // sample on the first released tick of the slot
        if (m_ticks == '0 && m_units == '0) m_shift = {level, m_shift[BYTE_W-1:1]};
        if (units_done(SLOT_UNITS)) begin
          m_bit = m_bit + 1'b1;
          if (m_bit != '0) begin
            m_phase = p - 1'b1;
          end else if (p == SEQ_LAST) begin
            // sign nibble masked off
            m_temp = {m_shift[3:0], m_low};
            w.done = 1'b1;
            enter_step(32'(SEQ_IDLE));
          end else begin
            m_low = m_shift;
            enter_step(32'(p) + 1);
          end
        end
      end
    endcase
    w.presence = m_presence;
    w.temp     = m_temp;
    return w;
  endfunction

  task automatic report_mismatch(input string what, input logic [TEMP_W-1:0] got,
                                 input logic [TEMP_W-1:0] want);
    if (n_fail < 30) $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
    n_fail++;
  endtask

  always @(posedge clk) begin : watch
    reader_word_t want;
    if (!rst_n) begin
      r_tpu      = TPU_AT_RESET;
      r_slot     = SLOT_AT_RESET;
      r_cwu      = CWU_AT_RESET;
      m_phase    = SEQ_IDLE;
      m_ticks    = '0;
      m_units    = '0;
      m_bit      = '0;
      m_shift    = '0;
      m_low      = '0;
      m_temp     = '0;
      m_presence = 1'b0;
      expected_words.delete();
      n_fed     <= 0;
      n_matched <= 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_TICKS_PER_UNIT:     r_tpu  = cfg_ch.data;
          REG_SLOT_LOW_TICKS:     r_slot = cfg_ch.data[SLOT_W-1:0];
          REG_CONVERT_WAIT_UNITS: r_cwu  = cfg_ch.data;
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected result word", '0, '0);
        end else begin
          want = expected_words.pop_front();
          n_matched <= n_matched + 1;
          n_words++;
          if (out_ch.done_res === 1'b1) n_done++;
          if (out_ch.drive_low !== want.drive)
            report_mismatch("drive_low", TEMP_W'(out_ch.drive_low), TEMP_W'(want.drive));
          if (out_ch.busy_res !== want.busy)
            report_mismatch("busy_res", TEMP_W'(out_ch.busy_res), TEMP_W'(want.busy));
          if (out_ch.done_res !== want.done)
            report_mismatch("done_res", TEMP_W'(out_ch.done_res), TEMP_W'(want.done));
          if (out_ch.presence_seen !== want.presence)
            report_mismatch("presence_seen", TEMP_W'(out_ch.presence_seen),
                            TEMP_W'(want.presence));
          if (out_ch.temperature !== want.temp)
            report_mismatch("temperature", out_ch.temperature, want.temp);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_words.push_back(next_bus_word(in_ch.start_req, in_ch.line_level));
        n_fed <= n_fed + 1;
      end
    end
  end

endmodule

@@ verif/tb_onewire_temperature_reader_top.sv @@
`timescale 1ns / 100ps

module tb_onewire_temperature_reader_top;
  import owtr_pkg::*;

  // Run length. Random part stops once enough ticks were fed; the cycle
  // limit catches a hang.
  localparam int unsigned CYCLE_LIMIT     = 2_000_000;
  localparam int unsigned RANDOM_TICKS    = 1600;
  localparam int unsigned MAX_SETTINGS    = 40;

  // Unused register index: writes to it must leave the timing alone
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // What the far end of the bus does to the line
  localparam int unsigned LINE_RANDOM      = 0;
  localparam int unsigned LINE_HIGH        = 1;  // no device: reads all ones
  localparam int unsigned LINE_LOW         = 2;  // line stuck low: reads all zeros
  localparam int unsigned LINE_MOSTLY_HIGH = 3;

  // Receiver stall patterns, taken in turn by sink_cyc[9:8]
  localparam logic [1:0] SINK_FREE     = 2'd0;
  localparam logic [1:0] SINK_RANDOM   = 2'd1;
  localparam logic [1:0] SINK_PERIODIC = 2'd2;
  localparam logic [1:0] SINK_HEAVY    = 2'd3;

  logic clk;
  logic rst_n;

  owtr_in_if  in_if();
  owtr_out_if out_if();
  owtr_cfg_if cfg_if();

  int unsigned fail_cnt;
  int unsigned open_words;
  int unsigned done_seen;
  int unsigned words_checked;

  int unsigned cycle_cnt    = 0;
  int unsigned fed_ticks    = 0;
  int unsigned settings_run = 0;
  logic [9:0]  sink_cyc     = '0;

  onewire_temperature_reader_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // Predicts every result word and compares; hands back the failure count
  owtr_reading_check u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_if),
    .out_ch        (out_if),
    .cfg_ch        (cfg_if),
    .fail_cnt      (fail_cnt),
    .open_words    (open_words),
    .done_seen     (done_seen),
    .words_checked (words_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hang guard
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still open", cycle_cnt, open_words);
      $display("** onewire_temperature_reader_top: FAILED **");
      $finish;
    end
  end

  // Receiver: rotates through free-running, random, periodic and heavy stalls
  always @(posedge clk) begin
    sink_cyc <= sink_cyc + 10'd1;
    case (sink_cyc[9:8])
      SINK_FREE:     out_if.ready <= 1'b1;
      SINK_RANDOM:   out_if.ready <= ($urandom_range(0, 3) != 0);
      SINK_PERIODIC: out_if.ready <= (sink_cyc[2:1] != 2'd0);
      SINK_HEAVY:    out_if.ready <= ($urandom_range(0, 7) == 0);
      default: ;
    endcase
  end

  // One bus tick word; returns at the edge that takes it. valid stays high
  // so back-to-back calls stream with no bubble.
  task automatic send_tick(input logic want_start, input logic level);
    in_if.valid      <= 1'b1;
    in_if.start_req  <= want_start;
    in_if.line_level <= level;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // Register write; caller drops valid after the last one
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
  endtask

  initial begin
    logic [CNT_W-1:0]     tpu;
    logic [CFG_DAT_W-1:0] slot_word;
    logic [CNT_W-1:0]     cwu;
    int unsigned          line_mode;
    int unsigned          span;
    int unsigned          sent;
    int unsigned          burst;
    int unsigned          gap;
    int unsigned          pick;
    logic                 level;

    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.start_req  = 1'b0;
    in_if.line_level = 1'b1;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = REG_TICKS_PER_UNIT;
    cfg_if.data      = '0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset timing, idle with no start on either line level, a
    // start, then start requests while the sequence runs (must be ignored).
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
    repeat (15) send_tick($urandom_range(0, 1) == 1, $urandom_range(0, 1) == 1);

    // Random part: one timing setting per pass. Settings change only with
    // no word in flight, but the bus sequence is usually mid-run, so a
    // shortened segment must end on the next tick.
    while (settings_run < MAX_SETTINGS && fed_ticks < RANDOM_TICKS) begin
      case (settings_run)
        0: begin
          // all zero: every register acts as one
          tpu = '0; slot_word = '0; cwu = '0; line_mode = LINE_HIGH; span = 600;
        end
        1: begin
          // upper extremes, upper slot byte set too (masked); partial run only
          tpu = '1; slot_word = '1; cwu = '1; line_mode = LINE_RANDOM; span = 100;
        end
        2: begin
          tpu = 16'd1; slot_word = 16'd1; cwu = 16'd1; line_mode = LINE_LOW; span = 600;
        end
        3: begin
          tpu = 16'd1; slot_word = 16'd255; cwu = 16'd2; line_mode = LINE_RANDOM; span = 100;
        end
        default: begin
          pick = $urandom_range(0, 19);
          if (pick < 3)       tpu = '0;
          else if (pick < 14) tpu = 16'd1;
          else                tpu = 16'($urandom_range(2, 4));
          slot_word = {8'($urandom_range(0, 255)),
                       ($urandom_range(0, 3) != 0) ? 8'($urandom_range(1, 4))
                                                   : 8'($urandom_range(0, 20))};
          cwu       = 16'($urandom_range(0, 40));
          line_mode = $urandom_range(0, 3);
          span      = $urandom_range(100, 250);
        end
      endcase

      // drain, then reprogram
      in_if.valid <= 1'b0;
      do @(posedge clk); while (open_words != 0);
      write_reg(REG_TICKS_PER_UNIT, tpu);
      write_reg(REG_SLOT_LOW_TICKS, slot_word);
      write_reg(REG_CONVERT_WAIT_UNITS, cwu);
      if (settings_run == 3) write_reg(REG_SPARE, 16'hFFFF);
      cfg_if.valid <= 1'b0;
      settings_run++;

      // bursts of ticks with random gaps; about a third of bursts run on
      sent = 0;
      while (sent < span) begin
        burst = $urandom_range(1, 40);
        repeat (burst) begin
          case (line_mode)
            LINE_HIGH:        level = 1'b1;
            LINE_LOW:         level = 1'b0;
            LINE_MOSTLY_HIGH: level = ($urandom_range(0, 7) != 0);
            default:          level = ($urandom_range(0, 1) == 1);
          endcase
          send_tick($urandom_range(0, 3) != 0, level);
        end
        sent      += burst;
        fed_ticks += burst;
        if ($urandom_range(0, 2) != 0) begin
          gap = $urandom_range(1, 6);
          in_if.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end

    // Wait for the last results, then a short quiet tail
    in_if.valid <= 1'b0;
    while (open_words != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Checked %0d result words over %0d timing settings, %0d random ticks.",
             words_checked, settings_run + 1, fed_ticks);
    $display("Completed temperature readings: %0d, failures: %0d.", done_seen, fail_cnt);
    if (fail_cnt == 0) begin
      $display("** onewire_temperature_reader_top: PASSED **");
    end else begin
      $display("** onewire_temperature_reader_top: FAILED **");
    end
    $finish;
  end

endmodule
